>>> hdl/table_dfa_recognizer_core_assert.svh
// Assertion macros for the table-driven DFA recognizer core.
`ifndef TABLE_DFA_RECOGNIZER_CORE_ASSERT_SVH
`define TABLE_DFA_RECOGNIZER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define TDR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TDR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDR_ASSERT(label, clk, rst_n, prop, msg)
`define TDR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> hdl/tdr_pkg.sv
// Shared types and constants of the DFA recognizer core.
`default_nettype none

package tdr_pkg;

  localparam int unsigned STATE_W  = 6;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned TOK_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ENTRY_W  = STATE_W + 1;

  localparam int unsigned NUM_STATES_DEF  = 64;
  localparam int unsigned SYMBOL_BITS_DEF = 8;
  localparam int unsigned TOKEN_BITS_DEF  = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET_TRANS = 3'd0,
    FUNC_SET_ELSE  = 3'd1,
    FUNC_SET_INFO  = 3'd2,
    FUNC_SET_START = 3'd3,
    FUNC_SYMBOL    = 3'd4,
    FUNC_EMPTY     = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_LOAD_DONE = 2'd0,
    STATUS_RUNNING   = 2'd1,
    STATUS_ACCEPTED  = 2'd2,
    STATUS_REJECTED  = 2'd3
  } status_e;

  // Work left for a word after the step stage.
  typedef enum logic [1:0] {
    OP_DONE  = 2'd0,
    OP_LAST  = 2'd1,
    OP_ELSE  = 2'd2,
    OP_FINAL = 2'd3
  } op_e;

  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] target;
  } entry_t;

  typedef struct packed {
    status_e            status;
    logic [STATE_W-1:0] end_state;
    logic [TOK_W-1:0]   token;
    logic               backtrack;
  } result_t;

  typedef struct packed {
    op_e                op;
    logic [STATE_W-1:0] state;
    result_t            res;
  } stage_t;

endpackage

`default_nettype wire

>>> hdl/tdr_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module tdr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_a_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  input  wire logic             re_b_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

>>> hdl/table_dfa_recognizer_core.sv
// Table-driven DFA recognizer: loadable transition memory and a four-stage pipeline.
//
// One input word is taken every cycle while the output side does not stall, and each word
// yields exactly one result word, in order. Per cycle the step stage
// reads one row of the transition memory (all symbol transitions, else transition and info of a
// state) at the current state; the next state is chosen from that row, so a symbol follows the
// previous one in the next cycle. The final else step of a string and the accepting-state check
// use a copy of the else and info fields in a second memory over the two stages that follow.
// Load words write the row of their state read-modify-write in the step stage. After
// reset a clearing sweep writes one row per cycle over all NUM_STATES rows; in_ready_o stays low
// until it ends.
`default_nettype none
`include "table_dfa_recognizer_core_assert.svh"

module table_dfa_recognizer_core #(
  parameter int unsigned NUM_STATES  = tdr_pkg::NUM_STATES_DEF,
  parameter int unsigned SYMBOL_BITS = tdr_pkg::SYMBOL_BITS_DEF,
  parameter int unsigned TOKEN_BITS  = tdr_pkg::TOKEN_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [tdr_pkg::FUNC_W-1:0]    func_i,
  input  wire logic [tdr_pkg::STATE_W-1:0]   from_state_i,
  input  wire logic [tdr_pkg::SYM_W-1:0]     symbol_i,
  input  wire logic [tdr_pkg::STATE_W-1:0]   to_state_i,
  input  wire logic                          is_final_i,
  input  wire logic                          needs_backtrack_i,
  input  wire logic [tdr_pkg::TOK_W-1:0]     token_type_i,
  input  wire logic                          last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [tdr_pkg::STATUS_W-1:0]  status_o,
  output logic      [tdr_pkg::STATE_W-1:0]   end_state_o,
  output logic      [tdr_pkg::TOK_W-1:0]     accept_token_o,
  output logic                               accept_backtrack_o
);

  localparam int unsigned SW      = tdr_pkg::STATE_W;
  localparam int unsigned TW      = tdr_pkg::TOK_W;
  localparam int unsigned NSYM    = 1 << SYMBOL_BITS;
  localparam int unsigned AW      = $clog2(NUM_STATES);
  localparam int unsigned EW      = tdr_pkg::ENTRY_W;
  localparam int unsigned IW      = TOKEN_BITS + 2;
  localparam int unsigned TRANS_W = NSYM * EW;
  localparam int unsigned EI_W    = EW + IW;
  localparam int unsigned ROW_W   = TRANS_W + EI_W;

  function automatic logic [AW-1:0] to_addr(input logic [SW-1:0] s);
    logic [AW+SW-1:0] ext;
    ext = {{AW{1'b0}}, s};
    return ext[AW-1:0];
  endfunction

  function automatic logic in_range(input logic [SW-1:0] s);
    return (32'(s) < NUM_STATES);
  endfunction

  function automatic logic [TOKEN_BITS-1:0] tok_in(input logic [TW-1:0] t);
    logic [TOKEN_BITS+TW-1:0] ext;
    ext = {{TOKEN_BITS{1'b0}}, t};
    return ext[TOKEN_BITS-1:0];
  endfunction

  function automatic logic [TW-1:0] tok_out(input logic [TOKEN_BITS-1:0] t);
    logic [TOKEN_BITS+TW-1:0] ext;
    ext = {{TW{1'b0}}, t};
    return ext[TW-1:0];
  endfunction

  // Apply the write of the previous edge to a row read at that same edge.
  function automatic logic [ROW_W-1:0] patch_row(
    input logic [ROW_W-1:0]       row,
    input logic                   hit,
    input logic [2:0]             pfunc,
    input logic [SYMBOL_BITS-1:0] psym,
    input logic [EW-1:0]          pentry,
    input logic [IW-1:0]          pinfo
  );
    logic [ROW_W-1:0] r;
    r = row;
    if (hit) begin
      priority if (pfunc == tdr_pkg::FUNC_SET_TRANS) begin
        r[psym*EW +: EW] = pentry;
      end else if (pfunc == tdr_pkg::FUNC_SET_ELSE) begin
        r[TRANS_W +: EW] = pentry;
      end else begin
        r[TRANS_W+EW +: IW] = pinfo;
      end
    end
    return r;
  endfunction

  // clearing sweep
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;
  logic          clr_last;

  // handshake chain
  logic in_go, out_free, s1_go, s2_go, s3_go;

  // step stage
  logic                   s1_vld_q;
  logic [2:0]             s1_func_q;
  logic [SW-1:0]          s1_from_q;
  logic [SYMBOL_BITS-1:0] s1_sym_q;
  logic [SW-1:0]          s1_to_q;
  logic                   s1_fin_q;
  logic                   s1_bt_q;
  logic [TW-1:0]          s1_tok_q;
  logic                   s1_last_q;

  logic [SW-1:0] cur_q, cur_nx, cur_d;
  logic          dead_q, dead_nx, dead_d;
  logic [SW-1:0] start_q, start_nx, start_d;

  // write forwarding
  logic                   pt_vld_q;
  logic [2:0]             pt_func_q;
  logic [AW-1:0]          pt_addr_q;
  logic [SYMBOL_BITS-1:0] pt_sym_q;
  logic [EW-1:0]          pt_entry_q;
  logic [IW-1:0]          pt_info_q;

  logic [ROW_W-1:0] row_a_raw, row_b_raw, row_a, row_b, wr_row, ram_wdata;
  logic [EI_W-1:0]  ei_a_raw, ei_b_raw;
  logic             wr_req, wr_en, ram_we;
  logic [AW-1:0]    ram_waddr;

  tdr_pkg::entry_t ta, ea, tb, eb;
  logic            step_ok;
  logic [SW-1:0]   step_n;
  logic [IW-1:0]   info_in;

  tdr_pkg::stage_t s1_out, s2_q, s2_out, s3_q, s3_out;
  logic            s2_vld_q, s3_vld_q;

  tdr_pkg::result_t out_q;
  logic             out_vld_q;

  // S2 / S3 lookups
  logic [EI_W-1:0] ei2, ei3;
  tdr_pkg::entry_t e2;
  logic [IW-1:0]   info2, info3;

  assign clr_last = (32'(clr_addr_q) == NUM_STATES - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_last) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  assign out_free   = !out_vld_q || out_ready_i;
  assign s3_go      = s3_vld_q && out_free;
  assign s2_go      = s2_vld_q && (!s3_vld_q || s3_go);
  assign s1_go      = s1_vld_q && (!s2_vld_q || s2_go);
  assign in_ready_o = !clr_busy_q && (!s1_vld_q || s1_go);
  assign in_go      = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_go) begin
      s1_vld_q <= 1'b1;
    end else if (s1_go) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      s1_func_q <= func_i;
      s1_from_q <= from_state_i;
      s1_sym_q  <= symbol_i[SYMBOL_BITS-1:0];
      s1_to_q   <= to_state_i;
      s1_fin_q  <= is_final_i;
      s1_bt_q   <= needs_backtrack_i;
      s1_tok_q  <= token_type_i;
      s1_last_q <= last_i;
    end
  end

  // rows of the current state and of the load target, with the last write folded in
  always_comb begin
    row_a = patch_row(row_a_raw, pt_vld_q && (pt_addr_q == to_addr(cur_q)),
                      pt_func_q, pt_sym_q, pt_entry_q, pt_info_q);
    row_b = patch_row(row_b_raw, pt_vld_q && (pt_addr_q == to_addr(s1_from_q)),
                      pt_func_q, pt_sym_q, pt_entry_q, pt_info_q);
    if (!in_range(cur_q)) begin
      row_a = '0;
    end
    if (!in_range(s1_from_q)) begin
      row_b = '0;
    end
  end

  assign ta      = row_a[s1_sym_q*EW +: EW];
  assign ea      = row_a[TRANS_W +: EW];
  assign tb      = row_b[s1_sym_q*EW +: EW];
  assign eb      = row_b[TRANS_W +: EW];
  assign step_ok = ta.valid || ea.valid;
  assign step_n  = ta.valid ? ta.target : ea.target;
  assign info_in = {s1_fin_q, s1_bt_q, tok_in(s1_tok_q)};

  always_comb begin
    cur_nx   = cur_q;
    dead_nx  = dead_q;
    start_nx = start_q;
    wr_row   = row_b;
    wr_req   = 1'b0;
    s1_out.op            = tdr_pkg::OP_DONE;
    s1_out.state         = cur_q;
    s1_out.res.status    = tdr_pkg::STATUS_LOAD_DONE;
    s1_out.res.end_state = cur_q;
    s1_out.res.token     = '0;
    s1_out.res.backtrack = 1'b0;
    unique case (s1_func_q)
      tdr_pkg::FUNC_SET_TRANS: begin
        if (in_range(s1_from_q) && !tb.valid) begin
          wr_req = 1'b1;
          wr_row[s1_sym_q*EW +: EW] = {1'b1, s1_to_q};
        end
      end
      tdr_pkg::FUNC_SET_ELSE: begin
        if (in_range(s1_from_q) && !eb.valid) begin
          wr_req = 1'b1;
          wr_row[TRANS_W +: EW] = {1'b1, s1_to_q};
        end
      end
      tdr_pkg::FUNC_SET_INFO: begin
        if (in_range(s1_from_q)) begin
          wr_req = 1'b1;
          wr_row[TRANS_W+EW +: IW] = info_in;
        end
      end
      tdr_pkg::FUNC_SET_START: begin
        start_nx = s1_to_q;
        cur_nx   = s1_to_q;
        dead_nx  = 1'b0;
        s1_out.res.end_state = s1_to_q;
      end
      tdr_pkg::FUNC_SYMBOL: begin
        if (dead_q || !step_ok) begin
          s1_out.res.status = tdr_pkg::STATUS_REJECTED;
          if (s1_last_q) begin
            cur_nx  = start_q;
            dead_nx = 1'b0;
          end else begin
            dead_nx = 1'b1;
          end
        end else if (!s1_last_q) begin
          cur_nx = step_n;
          s1_out.res.status    = tdr_pkg::STATUS_RUNNING;
          s1_out.res.end_state = step_n;
        end else begin
          s1_out.op    = tdr_pkg::OP_LAST;
          s1_out.state = step_n;
          cur_nx  = start_q;
          dead_nx = 1'b0;
        end
      end
      tdr_pkg::FUNC_EMPTY: begin
        s1_out.op    = tdr_pkg::OP_ELSE;
        s1_out.state = start_q;
        cur_nx  = start_q;
        dead_nx = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign cur_d   = s1_go ? cur_nx : cur_q;
  assign dead_d  = s1_go ? dead_nx : dead_q;
  assign start_d = s1_go ? start_nx : start_q;
  assign wr_en   = s1_go && wr_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      dead_q   <= 1'b0;
      start_q  <= '0;
      pt_vld_q <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      dead_q   <= dead_d;
      start_q  <= start_d;
      pt_vld_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pt_func_q  <= s1_func_q;
      pt_addr_q  <= to_addr(s1_from_q);
      pt_sym_q   <= s1_sym_q;
      pt_entry_q <= {1'b1, s1_to_q};
      pt_info_q  <= info_in;
    end
  end

  assign ram_we    = clr_busy_q || wr_en;
  assign ram_waddr = clr_busy_q ? clr_addr_q : to_addr(s1_from_q);
  assign ram_wdata = clr_busy_q ? '0 : wr_row;

  tdr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_STATES)
  ) u_row_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_a_i    (1'b1),
    .raddr_a_i (to_addr(cur_d)),
    .rdata_a_o (row_a_raw),
    .re_b_i    (1'b1),
    .raddr_b_i (to_addr(in_go ? from_state_i : s1_from_q)),
    .rdata_b_o (row_b_raw)
  );

  tdr_ram #(
    .WIDTH (EI_W),
    .DEPTH (NUM_STATES)
  ) u_ei_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata[TRANS_W +: EI_W]),
    .re_a_i    (s1_go),
    .raddr_a_i (to_addr(s1_out.state)),
    .rdata_a_o (ei_a_raw),
    .re_b_i    (s2_go),
    .raddr_b_i (to_addr(s2_out.state)),
    .rdata_b_o (ei_b_raw)
  );

  // S2: final check of the reached state, else step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s1_go) begin
      s2_vld_q <= 1'b1;
    end else if (s2_go) begin
      s2_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_q <= s1_out;
    end
  end

  assign ei2   = in_range(s2_q.state) ? ei_a_raw : '0;
  assign e2    = ei2[EW-1:0];
  assign info2 = ei2[EW +: IW];

  always_comb begin
    s2_out = s2_q;
    priority if (s2_q.op == tdr_pkg::OP_LAST && info2[IW-1]) begin
      s2_out.op            = tdr_pkg::OP_DONE;
      s2_out.res.status    = tdr_pkg::STATUS_ACCEPTED;
      s2_out.res.end_state = s2_q.state;
      s2_out.res.token     = tok_out(info2[TOKEN_BITS-1:0]);
      s2_out.res.backtrack = info2[IW-2];
    end else if (s2_q.op == tdr_pkg::OP_LAST || s2_q.op == tdr_pkg::OP_ELSE) begin
      if (e2.valid) begin
        s2_out.op    = tdr_pkg::OP_FINAL;
        s2_out.state = e2.target;
      end else begin
        s2_out.op            = tdr_pkg::OP_DONE;
        s2_out.res.status    = tdr_pkg::STATUS_REJECTED;
        s2_out.res.end_state = s2_q.state;
        s2_out.res.token     = '0;
        s2_out.res.backtrack = 1'b0;
      end
    end else begin
    end
  end

  // S3: final check after the else step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (s2_go) begin
      s3_vld_q <= 1'b1;
    end else if (s3_go) begin
      s3_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      s3_q <= s2_out;
    end
  end

  assign ei3   = in_range(s3_q.state) ? ei_b_raw : '0;
  assign info3 = ei3[EW +: IW];

  always_comb begin
    s3_out = s3_q;
    if (s3_q.op == tdr_pkg::OP_FINAL) begin
      s3_out.op            = tdr_pkg::OP_DONE;
      s3_out.res.end_state = s3_q.state;
      if (info3[IW-1]) begin
        s3_out.res.status    = tdr_pkg::STATUS_ACCEPTED;
        s3_out.res.token     = tok_out(info3[TOKEN_BITS-1:0]);
        s3_out.res.backtrack = info3[IW-2];
      end else begin
        s3_out.res.status    = tdr_pkg::STATUS_REJECTED;
        s3_out.res.token     = '0;
        s3_out.res.backtrack = 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s3_go) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_go) begin
      out_q <= s3_out.res;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign status_o           = out_q.status;
  assign end_state_o        = out_q.end_state;
  assign accept_token_o     = out_q.token;
  assign accept_backtrack_o = out_q.backtrack;

  `TDR_ASSERT_ALWAYS(a_empty_while_clearing, clk_i, clr_busy_q |-> !(s1_vld_q || s2_vld_q || s3_vld_q || out_vld_q), "pipeline holds a word during the clearing sweep")
  `TDR_ASSERT(a_clear_length, clk_i, rst_ni, $fell(clr_busy_q) |-> $past(clr_last), "clearing sweep ended before the last row")
  `TDR_ASSERT(a_dead_cause, clk_i, rst_ni, $rose(dead_q) |-> $past(s1_go && !s1_last_q && (s1_func_q == tdr_pkg::FUNC_SYMBOL)), "dead run set without a failing symbol")
  `TDR_ASSERT(a_accept_in_range, clk_i, rst_ni, (out_vld_q && (out_q.status == tdr_pkg::STATUS_ACCEPTED)) |-> (32'(out_q.end_state) < NUM_STATES), "accepting state outside the table")

endmodule

`default_nettype wire

>>> dv/table_dfa_recognizer_core_tb.sv
// Self-checking testbench for the table-driven DFA recognizer core.
`default_nettype none

module table_dfa_recognizer_core_tb;
  import tdr_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;
  localparam int NUM_DIR      = 28;
  localparam int NUM_PHASES   = 5;
  localparam int PHASE_WORDS  = 140;
  localparam int HOLD_CYCLES  = 60;
  localparam int MAX_GAP      = 40;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [STATE_W-1:0] from_st;
    logic [SYM_W-1:0]   sym;
    logic [STATE_W-1:0] to_st;
    logic               fin;
    logic               bt;
    logic [TOK_W-1:0]   tok;
    logic               last;
  } dfa_word_t;

  typedef struct packed {
    dfa_word_t w;
    logic      typed;
    result_t   exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [FUNC_W-1:0] in_func = '0;
  logic [STATE_W-1:0] in_from = '0;
  logic [SYM_W-1:0] in_sym = '0;
  logic [STATE_W-1:0] in_to = '0;
  logic in_fin = 1'b0;
  logic in_bt = 1'b0;
  logic [TOK_W-1:0] in_tok = '0;
  logic in_last = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [STATE_W-1:0] out_state;
  logic [TOK_W-1:0] out_token;
  logic out_backtrack;

  // Predictor state.
  entry_t trans_mem [NUM_STATES_DEF][1 << SYM_W];
  entry_t else_mem [NUM_STATES_DEF];
  logic fin_mem [NUM_STATES_DEF];
  logic bt_mem [NUM_STATES_DEF];
  logic [TOK_W-1:0] tok_mem [NUM_STATES_DEF];
  logic [STATE_W-1:0] start_st;
  logic [STATE_W-1:0] cur_st;
  logic run_dead;

  result_t awaited_results[$];
  dir_row_t dir_tab [NUM_DIR];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_accepted = 0;
  int n_rejected = 0;
  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  logic [SYM_W-1:0] sym_base = '0;

  table_dfa_recognizer_core u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .func_i             (in_func),
    .from_state_i       (in_from),
    .symbol_i           (in_sym),
    .to_state_i         (in_to),
    .is_final_i         (in_fin),
    .needs_backtrack_i  (in_bt),
    .token_type_i       (in_tok),
    .last_i             (in_last),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .status_o           (out_status),
    .end_state_o        (out_state),
    .accept_token_o     (out_token),
    .accept_backtrack_o (out_backtrack)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t rejected_at(logic [STATE_W-1:0] s);
    rejected_at = '{status: STATUS_REJECTED, end_state: s, token: '0, backtrack: 1'b0};
  endfunction

  function automatic result_t accepted_at(logic [STATE_W-1:0] s);
    accepted_at = '{status: STATUS_ACCEPTED, end_state: s, token: tok_mem[s],
                    backtrack: bt_mem[s]};
  endfunction

  function automatic result_t final_else_from(logic [STATE_W-1:0] s);
    if (!else_mem[s].valid) return rejected_at(s);
    if (fin_mem[else_mem[s].target]) return accepted_at(else_mem[s].target);
    return rejected_at(else_mem[s].target);
  endfunction

  function automatic void restart_run();
    cur_st = start_st;
    run_dead = 1'b0;
  endfunction

  function automatic result_t dfa_advance(dfa_word_t w);
    result_t r;
    entry_t hop;
    r = '{status: STATUS_LOAD_DONE, end_state: '0, token: '0, backtrack: 1'b0};
    case (w.func)
      FUNC_SET_TRANS: begin
        if (!trans_mem[w.from_st][w.sym].valid)
          trans_mem[w.from_st][w.sym] = '{valid: 1'b1, target: w.to_st};
      end
      FUNC_SET_ELSE: begin
        if (!else_mem[w.from_st].valid) else_mem[w.from_st] = '{valid: 1'b1, target: w.to_st};
      end
      FUNC_SET_INFO: begin
        fin_mem[w.from_st] = w.fin;
        bt_mem[w.from_st] = w.bt;
        tok_mem[w.from_st] = w.tok;
      end
      FUNC_SET_START: begin
        start_st = w.to_st;
        restart_run();
      end
      FUNC_SYMBOL: begin
        hop = trans_mem[cur_st][w.sym];
        if (!hop.valid) hop = else_mem[cur_st];
        if (run_dead || !hop.valid) begin
          r = rejected_at(cur_st);
          if (w.last) restart_run();
          else run_dead = 1'b1;
        end else begin
          cur_st = hop.target;
          if (!w.last) begin
            r.status = STATUS_RUNNING;
            r.end_state = cur_st;
          end else begin
            r = fin_mem[cur_st] ? accepted_at(cur_st) : final_else_from(cur_st);
            restart_run();
          end
        end
      end
      FUNC_EMPTY: begin
        r = final_else_from(start_st);
        restart_run();
      end
      default: ;
    endcase
    if (w.func != FUNC_SYMBOL && w.func != FUNC_EMPTY) r.end_state = cur_st;
    return r;
  endfunction

  function automatic dir_row_t drow(logic typed, logic [FUNC_W-1:0] f, int from, int sym,
                                    int to, logic fin, logic bt, int tok, logic last,
                                    status_e st = STATUS_LOAD_DONE, int es = 0, int tk = 0,
                                    logic bk = 1'b0);
    drow.w = '{func: f, from_st: from[STATE_W-1:0], sym: sym[SYM_W-1:0],
               to_st: to[STATE_W-1:0], fin: fin, bt: bt, tok: tok[TOK_W-1:0], last: last};
    drow.typed = typed;
    drow.exp = '{status: st, end_state: es[STATE_W-1:0], token: tk[TOK_W-1:0], backtrack: bk};
  endfunction

  function automatic logic [STATE_W-1:0] pick_state();
    if ($urandom_range(0, 9) != 0) return STATE_W'($urandom_range(0, 11));
    return STATE_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [SYM_W-1:0] pick_sym();
    if ($urandom_range(0, 9) != 0) return sym_base + SYM_W'($urandom_range(0, 3));
    return SYM_W'($urandom_range(0, 255));
  endfunction

  function automatic dfa_word_t rand_word();
    dfa_word_t w;
    logic [63:0] noise;
    int roll;
    noise = {$urandom(), $urandom()};
    w = noise[$bits(dfa_word_t)-1:0];
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      w.func = FUNC_SET_TRANS;
      w.from_st = pick_state();
      w.sym = pick_sym();
      w.to_st = pick_state();
    end else if (roll < 18) begin
      w.func = FUNC_SET_ELSE;
      w.from_st = pick_state();
      w.to_st = pick_state();
    end else if (roll < 26) begin
      w.func = FUNC_SET_INFO;
      w.from_st = pick_state();
      w.fin = ($urandom_range(0, 9) < 4);
    end else if (roll < 28) begin
      w.func = FUNC_SET_START;
      w.to_st = ($urandom_range(0, 3) != 0) ? STATE_W'($urandom_range(0, 3)) : pick_state();
    end else if (roll < 31) begin
      w.func = FUNC_EMPTY;
    end else if (roll < 32) begin
      w.func = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
    end else begin
      w.func = FUNC_SYMBOL;
      w.sym = pick_sym();
      w.last = ($urandom_range(0, 4) == 0);
    end
    return w;
  endfunction

  // Offer one word, idling first as the phase asks; return at the accepting edge.
  task automatic send_word(dfa_word_t w);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
      gap++;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= w.func;
    in_from <= w.from_st;
    in_sym <= w.sym;
    in_to <= w.to_st;
    in_fin <= w.fin;
    in_bt <= w.bt;
    in_tok <= w.tok;
    in_last <= w.last;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string what, int e, int a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, e, a);
      errors++;
    end
  endfunction

  // Output side: random stalls plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d state %0d",
                 $time, out_status, out_state);
        errors++;
      end else begin
        e = awaited_results.pop_front();
        check_field("status", e.status, out_status);
        check_field("end_state", e.end_state, out_state);
        check_field("accept_token", e.token, out_token);
        check_field("accept_backtrack", e.backtrack, out_backtrack);
        n_checked++;
        if (out_status == STATUS_ACCEPTED) n_accepted++;
        if (out_status == STATUS_REJECTED) n_rejected++;
      end
    end
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int phase_send [NUM_PHASES];
    int phase_rcv [NUM_PHASES];
    dfa_word_t w;
    result_t r;
    phase_send = '{0, 75, 0, 26, 0};
    phase_rcv = '{0, 0, 75, 26, 0};
    for (int s = 0; s < NUM_STATES_DEF; s++) begin
      for (int c = 0; c < (1 << SYM_W); c++) trans_mem[s][c] = '0;
      else_mem[s] = '0;
      fin_mem[s] = 1'b0;
      bt_mem[s] = 1'b0;
      tok_mem[s] = '0;
    end
    start_st = '0;
    cur_st = '0;
    run_dead = 1'b0;

    dir_tab = '{
      drow(1, FUNC_SYMBOL,    0,  8'h00, 0,  0, 0, 0,     0, STATUS_REJECTED, 0),
      drow(1, FUNC_SYMBOL,    0,  8'hff, 0,  0, 0, 0,     1, STATUS_REJECTED, 0),
      drow(1, FUNC_EMPTY,     0,  8'h00, 0,  0, 0, 0,     0, STATUS_REJECTED, 0),
      drow(1, FUNC_SPARE_A,   63, 8'hff, 63, 1, 1, 8'hff, 1),
      drow(1, FUNC_SPARE_B,   63, 8'hff, 63, 1, 1, 8'hff, 0),
      drow(1, FUNC_SET_TRANS, 0,  8'h61, 1,  0, 0, 0,     0),
      drow(1, FUNC_SET_TRANS, 0,  8'h61, 5,  0, 0, 0,     0),
      drow(1, FUNC_SET_TRANS, 1,  8'hff, 63, 0, 0, 0,     0),
      drow(1, FUNC_SET_INFO,  63, 8'h00, 0,  1, 1, 8'hff, 0),
      drow(1, FUNC_SET_ELSE,  1,  8'h00, 2,  0, 0, 0,     0),
      drow(1, FUNC_SET_ELSE,  1,  8'h00, 3,  0, 0, 0,     0),
      drow(1, FUNC_SET_INFO,  2,  8'h00, 0,  1, 0, 8'h5a, 0),
      drow(0, FUNC_SYMBOL,    0,  8'h61, 0,  0, 0, 0,     0),
      drow(1, FUNC_SYMBOL,    0,  8'hff, 0,  0, 0, 0,     1, STATUS_ACCEPTED, 63, 255, 1),
      drow(0, FUNC_SYMBOL,    0,  8'h61, 0,  0, 0, 0,     1),
      drow(0, FUNC_SYMBOL,    0,  8'h00, 0,  0, 0, 0,     0),
      drow(0, FUNC_SYMBOL,    0,  8'h61, 0,  0, 0, 0,     0),
      drow(0, FUNC_EMPTY,     0,  8'h00, 0,  0, 0, 0,     0),
      drow(1, FUNC_SET_ELSE,  0,  8'h00, 2,  0, 0, 0,     0),
      drow(0, FUNC_EMPTY,     0,  8'h00, 0,  0, 0, 0,     0),
      drow(1, FUNC_SET_START, 0,  8'h00, 63, 0, 0, 0,     0, STATUS_LOAD_DONE, 63),
      drow(0, FUNC_SYMBOL,    0,  8'h00, 0,  0, 0, 0,     1),
      drow(1, FUNC_SET_START, 0,  8'h00, 0,  0, 0, 0,     0),
      drow(0, FUNC_SYMBOL,    0,  8'h61, 0,  0, 0, 0,     0),
      drow(0, FUNC_SET_INFO,  0,  8'h00, 0,  0, 0, 0,     0),
      drow(0, FUNC_SET_START, 0,  8'h00, 0,  0, 0, 0,     0),
      drow(0, FUNC_SYMBOL,    0,  8'h61, 0,  0, 0, 0,     0),
      drow(0, FUNC_EMPTY,     0,  8'h00, 0,  0, 0, 0,     0)
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIR; i++) begin
      send_word(dir_tab[i].w);
      r = dfa_advance(dir_tab[i].w);
      awaited_results.push_back(dir_tab[i].typed ? dir_tab[i].exp : r);
    end
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = phase_send[p];
      rcv_stall_pct = phase_rcv[p];
      sym_base = SYM_W'($urandom_range(0, 255));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // Long output hold-off while words keep coming: fills the pipe.
        if (p == NUM_PHASES - 1 && (i == 0 || i == PHASE_WORDS / 2)) hold_requests++;
        w = rand_word();
        send_word(w);
        awaited_results.push_back(dfa_advance(w));
      end
      wait_drained();
    end

    rcv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d words over %0d idle patterns with long output holds", n_sent,
             NUM_PHASES);
    $display("checked %0d results: %0d accepted, %0d rejected, %0d errors", n_checked,
             n_accepted, n_rejected, errors);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> table_dfa_recognizer_core.f
+incdir+hdl
hdl/tdr_pkg.sv
hdl/tdr_ram.sv
hdl/table_dfa_recognizer_core.sv
dv/table_dfa_recognizer_core_tb.sv
